/* rtl/frt_pkg.sv */
package frt_pkg;

   localparam int CountWidth  = 16;
   localparam int ByteWidth   = 8;
   localparam int StatusWidth = 5;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   localparam logic [1:0] REG_STATUS = 2'd0;
   localparam logic [1:0] REG_HIGH   = 2'd1;
   localparam logic [1:0] REG_LOW    = 2'd2;

   localparam int OvfBit = 4;
   localparam int IenBit = 2;

   localparam logic [CountWidth-1:0] HIGH_LOAD = 16'hfff8;

   typedef struct packed {
      logic [1:0]           func;
      logic [1:0]           reg_select;
      logic [ByteWidth-1:0] write_byte;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] read_byte;
      logic                 irq;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_stream_type;

endpackage

/* rtl/frt_core.sv */
module frt_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_fire,
   input  frt_pkg::req_type req_data,
   output frt_pkg::rsp_type rsp_next
);
   import frt_pkg::*;

   logic [CountWidth-1:0]  count_ff, count_in;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic                   clear_armed_ff, clear_armed_in;
   logic [ByteWidth-1:0]   low_snap_ff, low_snap_in;
   logic                   low_snap_valid_ff, low_snap_valid_in;
   logic [ByteWidth-1:0]   high_buf_ff, high_buf_in;
   logic                   high_buf_valid_ff, high_buf_valid_in;
   logic                   irq_pending_ff, irq_pending_in;
   logic [CountWidth-1:0]  count_inc;
   logic [ByteWidth-1:0]   read_byte;

   assign count_inc = count_ff + CountWidth'(1);

   always_comb begin
      count_in          = count_ff;
      status_in         = status_ff;
      clear_armed_in    = clear_armed_ff;
      low_snap_in       = low_snap_ff;
      low_snap_valid_in = low_snap_valid_ff;
      high_buf_in       = high_buf_ff;
      high_buf_valid_in = high_buf_valid_ff;
      irq_pending_in    = irq_pending_ff;
      read_byte         = '0;
      case (req_data.func)
         FUNC_TICK: begin
            count_in = count_inc;
            if (count_inc == '0) begin
               status_in[OvfBit] = 1'b1;
               if (status_ff[IenBit]) begin
                  irq_pending_in = 1'b1;
               end
            end
         end
         FUNC_READ: begin
            case (req_data.reg_select)
               REG_STATUS: begin
                  if (status_ff[OvfBit]) begin
                     clear_armed_in = 1'b1;
                  end
                  read_byte = ByteWidth'(status_ff);
               end
               REG_HIGH: begin
                  // armed clear drops overflow and the pending interrupt
                  if (clear_armed_ff) begin
                     clear_armed_in    = 1'b0;
                     status_in[OvfBit] = 1'b0;
                     irq_pending_in    = 1'b0;
                  end
                  low_snap_in       = count_ff[ByteWidth-1:0];
                  low_snap_valid_in = 1'b1;
                  read_byte         = count_ff[CountWidth-1:ByteWidth];
               end
               REG_LOW: begin
                  if (low_snap_valid_ff) begin
                     low_snap_valid_in = 1'b0;
                     read_byte         = low_snap_ff;
                  end else begin
                     read_byte = count_ff[ByteWidth-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_WRITE: begin
            case (req_data.reg_select)
               REG_STATUS: begin
                  status_in = req_data.write_byte[StatusWidth-1:0];
               end
               REG_HIGH: begin
                  high_buf_in       = req_data.write_byte;
                  high_buf_valid_in = 1'b1;
                  count_in          = HIGH_LOAD;
               end
               REG_LOW: begin
                  if (high_buf_valid_ff) begin
                     high_buf_valid_in = 1'b0;
                     count_in          = {high_buf_ff, req_data.write_byte};
                  end else begin
                     count_in = {count_ff[CountWidth-1:ByteWidth], req_data.write_byte};
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign rsp_next.read_byte = read_byte;
   assign rsp_next.irq       = irq_pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff          <= '0;
         status_ff         <= '0;
         clear_armed_ff    <= 1'b0;
         low_snap_ff       <= '0;
         low_snap_valid_ff <= 1'b0;
         high_buf_ff       <= '0;
         high_buf_valid_ff <= 1'b0;
         irq_pending_ff    <= 1'b0;
      end else if (req_fire) begin
         count_ff          <= count_in;
         status_ff         <= status_in;
         clear_armed_ff    <= clear_armed_in;
         low_snap_ff       <= low_snap_in;
         low_snap_valid_ff <= low_snap_valid_in;
         high_buf_ff       <= high_buf_in;
         high_buf_valid_ff <= high_buf_valid_in;
         irq_pending_ff    <= irq_pending_in;
      end
   end

   a_armed_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.func == FUNC_READ && req_data.reg_select == REG_HIGH
      && clear_armed_ff |=> !irq_pending_ff && !status_ff[OvfBit] && !clear_armed_ff)
      else $error("armed high read did not clear overflow");

   a_wrap_sets_ovf: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.func == FUNC_TICK && count_ff == '1
      |=> status_ff[OvfBit] && count_ff == '0)
      else $error("counter wrap did not set overflow");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff) && $stable(status_ff) && $stable(irq_pending_ff))
      else $error("state changed without a request");

   a_irq_needs_ovf: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.func == FUNC_TICK && !irq_pending_ff && !status_ff[IenBit]
      |=> !irq_pending_ff)
      else $error("interrupt raised while disabled");

endmodule

/* rtl/frt_out_buf.sv */
module frt_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  frt_pkg::rsp_type        in_data,
   output frt_pkg::rsp_stream_type out_stream,
   input  logic                    out_ready
);
   import frt_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff, main_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    in_fire;
   logic    out_fire;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;
   assign out_fire = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_fire || !main_valid_ff) begin
         // skid entry is older, so it moves up first
         skid_valid_in = 1'b0;
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
         end else begin
            main_valid_in = in_fire;
            main_data_in  = in_data;
         end
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_stream.valid = main_valid_ff;
   assign out_stream.data  = main_data_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a main entry");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      main_valid_ff && !out_ready && in_fire |=> skid_valid_ff && main_valid_ff)
      else $error("request lost while output stalled");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_fire |=> main_valid_ff && !skid_valid_ff
      && main_data_ff == $past(skid_data_ff))
      else $error("skid entry not moved to output");

endmodule

/* rtl/free_running_timer_registers.sv */
// Byte-wide 16-bit free-running timer with status register. Each request (tick, register
// read or register write) is accepted, and its response is registered in an output register
// before it appears on the rsp_ channel; a second buffer entry lets a request be taken while a
// response waits, so the block sustains one request per clock while rsp_ready is high.
// req_ready drops only when both response entries are full. irq in each response is the
// interrupt pending after that request.
module free_running_timer_registers (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  frt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output frt_pkg::rsp_type rsp_data
);
   import frt_pkg::*;

   logic           req_fire;
   rsp_type        rsp_next;
   rsp_stream_type rsp_stream;

   assign req_fire = req_valid && req_ready;

   frt_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .rsp_next (rsp_next)
   );

   frt_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_data    (rsp_next),
      .out_stream (rsp_stream),
      .out_ready  (rsp_ready)
   );

   assign rsp_valid = rsp_stream.valid;
   assign rsp_data  = rsp_stream.data;

endmodule

/* bench/frt_scoreboard_pkg.sv */
`timescale 1ns / 100ps

package frt_scoreboard_pkg;
   import frt_pkg::*;

   class timer_scoreboard;
      // mirror of the timer registers
      logic [CountWidth-1:0]  count;
      logic [StatusWidth-1:0] status;
      logic                   clear_armed;
      logic [ByteWidth-1:0]   low_latch;
      logic                   low_latch_valid;
      logic [ByteWidth-1:0]   high_hold;
      logic                   high_hold_valid;
      logic                   irq_pending;

      rsp_type expected_rsp[$];
      int      errors;

      function new();
         count           = '0;
         status          = '0;
         clear_armed     = 1'b0;
         low_latch       = '0;
         low_latch_valid = 1'b0;
         high_hold       = '0;
         high_hold_valid = 1'b0;
         irq_pending     = 1'b0;
         errors          = 0;
      endfunction

      function rsp_type apply_request(req_type r);
         rsp_type               e;
         logic [CountWidth-1:0] snap;
         e = '0;
         case (r.func)
            FUNC_TICK: begin
               count = count + 1'b1;
               if (count == '0) begin
                  status[OvfBit] = 1'b1;
                  if (status[IenBit]) irq_pending = 1'b1;
               end
            end
            FUNC_READ: begin
               case (r.reg_select)
                  REG_STATUS: begin
                     if (status[OvfBit]) clear_armed = 1'b1;
                     e.read_byte = {3'b000, status};
                  end
                  REG_HIGH: begin
                     snap = count;
                     if (clear_armed) begin
                        clear_armed    = 1'b0;
                        status[OvfBit] = 1'b0;
                        irq_pending    = 1'b0;
                     end
                     low_latch       = snap[7:0];
                     low_latch_valid = 1'b1;
                     e.read_byte     = snap[15:8];
                  end
                  REG_LOW: begin
                     if (low_latch_valid) begin
                        low_latch_valid = 1'b0;
                        e.read_byte     = low_latch;
                     end else begin
                        e.read_byte = count[7:0];
                     end
                  end
                  default: ;
               endcase
            end
            FUNC_WRITE: begin
               case (r.reg_select)
                  REG_STATUS: status = r.write_byte[StatusWidth-1:0];
                  REG_HIGH: begin
                     high_hold       = r.write_byte;
                     high_hold_valid = 1'b1;
                     count           = HIGH_LOAD;
                  end
                  REG_LOW: begin
                     if (high_hold_valid) begin
                        high_hold_valid = 1'b0;
                        count           = {high_hold, r.write_byte};
                     end else begin
                        count[7:0] = r.write_byte;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         e.irq = irq_pending;
         return e;
      endfunction

      function void note_request(req_type r);
         expected_rsp.push_back(apply_request(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("response with no request outstanding: read_byte %0h irq %0b",
                   got.read_byte, got.irq);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (got.read_byte !== e.read_byte) begin
            $error("read_byte: expected %0h, got %0h", e.read_byte, got.read_byte);
            errors++;
         end
         if (got.irq !== e.irq) begin
            $error("irq: expected %0b, got %0b", e.irq, got.irq);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

endpackage

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
   import frt_pkg::*;
   import frt_scoreboard_pkg::*;

   // codes the block leaves unused
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] REG_UNUSED  = 2'd3;

   localparam int RandomItems = 1400;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   timer_scoreboard sb;
   int   sent;
   logic no_idle;
   int   stall_left;

   free_running_timer_registers uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_length();
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= idle_length() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
      end
   end

   task automatic issue(input logic [1:0] f, input logic [1:0] sel, input logic [7:0] wb);
      req_type r;
      int      gap;
      r.func       = f;
      r.reg_select = sel;
      r.write_byte = wb;
      gap = (no_idle || $urandom_range(0, 99) < 65) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= req_type'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // hold off until every outstanding request has been answered
   // (the loop steps the clock before it checks, so the last accepted request is already noted)
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic random_read();
      issue(FUNC_READ, 2'($urandom_range(0, 2)), 8'($urandom));
   endtask

   task automatic wrap_run();
      logic [7:0] st;
      logic [7:0] hi;
      int         n;
      st = 8'($urandom);
      if ($urandom_range(0, 3) != 0) st[IenBit] = 1'b1;
      hi = ($urandom_range(0, 9) < 7) ? 8'hff : 8'($urandom);
      n  = $urandom_range(1, 12);
      issue(FUNC_WRITE, REG_STATUS, st);
      issue(FUNC_WRITE, REG_HIGH, hi);
      if ($urandom_range(0, 1) == 1)
         issue(FUNC_WRITE, REG_LOW, 8'($urandom_range(8'hf0, 8'hff)));
      repeat (n) begin
         if ($urandom_range(0, 4) != 0) issue(FUNC_TICK, 2'($urandom), 8'($urandom));
         else random_read();
      end
   endtask

   task automatic clear_run();
      issue(FUNC_READ, REG_STATUS, 8'($urandom));
      if ($urandom_range(0, 2) == 0) issue(FUNC_TICK, 2'($urandom), 8'($urandom));
      if ($urandom_range(0, 3) == 0) issue(FUNC_WRITE, REG_STATUS, 8'($urandom));
      issue(FUNC_READ, REG_HIGH, 8'($urandom));
      issue(FUNC_READ, REG_LOW, 8'($urandom));
      if ($urandom_range(0, 1) == 1) issue(FUNC_READ, REG_LOW, 8'($urandom));
   endtask

   task automatic snapshot_run();
      int n;
      n = $urandom_range(0, 3);
      issue(FUNC_READ, REG_HIGH, 8'($urandom));
      repeat (n) issue(FUNC_TICK, 2'($urandom), 8'($urandom));
      if ($urandom_range(0, 2) == 0) issue(FUNC_WRITE, REG_LOW, 8'($urandom));
      issue(FUNC_READ, REG_LOW, 8'($urandom));
      issue(FUNC_READ, REG_LOW, 8'($urandom));
   endtask

   task automatic noise_run();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) issue(2'($urandom), 2'($urandom), 8'($urandom));
   endtask

   initial begin
      int total;
      sb         = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_ready  = 1'b0;
      no_idle    = 1'b0;
      stall_left = 0;
      sent       = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed
      issue(FUNC_READ, REG_STATUS, 8'h00);
      issue(FUNC_READ, REG_HIGH, 8'h00);
      issue(FUNC_READ, REG_LOW, 8'h00);
      issue(FUNC_READ, REG_LOW, 8'hff);
      issue(FUNC_READ, REG_UNUSED, 8'h00);
      issue(FUNC_WRITE, REG_UNUSED, 8'hff);
      issue(FUNC_UNUSED, REG_UNUSED, 8'hff);
      // status write sets overflow; clear happens with nothing pending
      issue(FUNC_WRITE, REG_STATUS, 8'hff);
      issue(FUNC_READ, REG_STATUS, 8'h00);
      issue(FUNC_READ, REG_HIGH, 8'h00);
      issue(FUNC_WRITE, REG_STATUS, 8'h04);
      issue(FUNC_WRITE, REG_HIGH, 8'hff);
      issue(FUNC_WRITE, REG_LOW, 8'hfe);
      issue(FUNC_TICK, REG_STATUS, 8'h00);
      issue(FUNC_TICK, REG_UNUSED, 8'hff);
      // second wrap while the interrupt is still pending
      issue(FUNC_WRITE, REG_HIGH, 8'hff);
      issue(FUNC_WRITE, REG_LOW, 8'hff);
      issue(FUNC_TICK, REG_HIGH, 8'h00);
      // enable dropped, interrupt stays until the armed high read
      issue(FUNC_WRITE, REG_STATUS, 8'h10);
      issue(FUNC_READ, REG_STATUS, 8'h00);
      issue(FUNC_READ, REG_HIGH, 8'h00);
      issue(FUNC_READ, REG_LOW, 8'h00);
      issue(FUNC_WRITE, REG_LOW, 8'h55);
      issue(FUNC_READ, REG_LOW, 8'h00);
      issue(FUNC_WRITE, REG_HIGH, 8'haa);
      drain();

      total = sent + RandomItems;
      while (sent < total) begin
         no_idle <= ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: wrap_run();
            3, 4:    clear_run();
            5, 6:    snapshot_run();
            default: noise_run();
         endcase
         if ($urandom_range(0, 39) == 0) drain();
      end

      drain();
      repeat (4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* free_running_timer_registers.f */
rtl/frt_pkg.sv
rtl/frt_core.sv
rtl/frt_out_buf.sv
rtl/free_running_timer_registers.sv
bench/frt_scoreboard_pkg.sv
bench/tb.sv
